// ===== rtl/core/pogq_pkg.sv =====
// ----------------------------------------------------------------------------
// pogq_pkg
// Types, codes and sizes shared by the upstream grant queue modules.
// ----------------------------------------------------------------------------
package pogq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD = CFG_IDX_W'(1);

  localparam logic [23:0] CAPACITY_RESET = 24'd1048576;
  localparam logic [11:0] OVERHEAD_RESET = 12'd0;

  localparam logic OP_ENQ   = 1'b0;
  localparam logic OP_GRANT = 1'b1;

  localparam int ENTRY_W = 14 + 16;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_REPORT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        op;
    logic [13:0] frame_bits;
    logic [15:0] frame_tag;
    logic [23:0] grant_bits;
    logic [7:0]  channel_id;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        accepted;
    logic [15:0] out_tag;
    logic [13:0] out_bits;
    logic [23:0] report_bits;
    logic [24:0] burst_bits;
    logic [7:0]  out_channel;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CHECK  = 2'd1,
    ST_REPORT = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic grant_start;
    logic enq;
    logic release_head;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic out_free;
    logic grant_go;
    logic fits;
    logic one_left;
  } dp_status_t;

endpackage

// ===== rtl/core/pogq_ram.sv =====
// ----------------------------------------------------------------------------
// pogq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pogq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pogq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pogq_ctrl
// Sequencer for enqueue and grant items: admits items, steps the head
// release loop and orders the burst report.
// ----------------------------------------------------------------------------
module pogq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_stall,
  input  pogq_pkg::dp_status_t status,
  output pogq_pkg::dp_cmd_t    cmd
);

  import pogq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        in_take;

  assign in_stall = (state_r != ST_IDLE) || status.out_valid;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_op == OP_GRANT) begin
            cmd.grant_start = 1'b1;
            state_nxt       = status.grant_go ? ST_CHECK : ST_REPORT;
          end else begin
            cmd.enq = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (status.out_free) begin
          if (status.fits) begin
            cmd.release_head = 1'b1;
            state_nxt        = status.one_left ? ST_REPORT : ST_CHECK;
          end else begin
            cmd.report = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_REPORT: begin
        if (status.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pogq_dp.sv =====
// ----------------------------------------------------------------------------
// pogq_dp
// Queue datapath: configuration registers, bit and entry accounting, head
// and tail pointers, frame store and the output beat register.
// ----------------------------------------------------------------------------
module pogq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pogq_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [pogq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pogq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pogq_pkg::out_item_t                 out_data,
  input  pogq_pkg::dp_cmd_t                   cmd,
  output pogq_pkg::dp_status_t                status
);

  import pogq_pkg::*;

  logic [23:0]      cap_r;
  logic [11:0]      ovh_r;
  logic [23:0]      queued_r,  queued_nxt;
  logic [PTR_W-1:0] head_r,    head_nxt;
  logic [PTR_W-1:0] tail_r,    tail_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r,  out_data_nxt;
  logic [23:0]      grant_r;
  logic [7:0]       chan_r;
  logic [23:0]      used_r,    used_nxt;

  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;
  logic               enq_ok;
  logic               ram_we;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [13:0]        rd_len;
  logic [15:0]        rd_tag;

  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);

  assign enq_ok = (({1'b0, queued_r} + 25'(in_data.frame_bits)) <= {1'b0, cap_r}) &&
                  (count_r < CNT_W'(QUEUE_DEPTH));

  assign ram_we    = cmd.enq && enq_ok;
  assign ram_re    = cmd.grant_start || cmd.release_head;
  assign ram_raddr = cmd.release_head ? head_inc : head_r;
  assign rd_len    = ram_rdata[ENTRY_W-1:16];
  assign rd_tag    = ram_rdata[15:0];

  pogq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({in_data.frame_bits, in_data.frame_tag}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.out_valid = out_valid_r;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.grant_go  = (in_data.grant_bits != '0) && (count_r != '0);
  assign status.fits      = (({1'b0, used_r} + 25'(rd_len)) <= {1'b0, grant_r});
  assign status.one_left  = (count_r == CNT_W'(1));

  always_comb begin
    queued_nxt    = queued_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.enq) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.kind     = KIND_STATUS;
      out_data_nxt.accepted = enq_ok;
      out_data_nxt.out_tag  = in_data.frame_tag;
      out_data_nxt.out_bits = in_data.frame_bits;
      out_data_nxt.last     = 1'b1;
      if (enq_ok) begin
        queued_nxt = queued_r + 24'(in_data.frame_bits);
        tail_nxt   = tail_inc;
        count_nxt  = count_r + CNT_W'(1);
      end
    end
    if (cmd.grant_start) begin
      used_nxt = '0;
    end
    if (cmd.release_head) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.kind     = KIND_RELEASE;
      out_data_nxt.out_tag  = rd_tag;
      out_data_nxt.out_bits = rd_len;
      queued_nxt = queued_r - 24'(rd_len);
      used_nxt   = used_r + 24'(rd_len);
      head_nxt   = head_inc;
      count_nxt  = count_r - CNT_W'(1);
    end
    if (cmd.report) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt.kind        = KIND_REPORT;
      out_data_nxt.report_bits = queued_r;
      out_data_nxt.burst_bits  = 25'(ovh_r) + 25'(used_r);
      out_data_nxt.out_channel = chan_r;
      out_data_nxt.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAPACITY_RESET;
      ovh_r       <= OVERHEAD_RESET;
      queued_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_CAPACITY)) begin
        cap_r <= cfg_data[23:0];
      end
      if (cfg_valid && (cfg_index == REG_OVERHEAD)) begin
        ovh_r <= cfg_data[11:0];
      end
      queued_r    <= queued_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    used_r     <= used_nxt;
    if (cmd.grant_start) begin
      grant_r <= in_data.grant_bits;
      chan_r  <= in_data.channel_id;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/pon_onu_grant_queue_unit.sv =====
// ----------------------------------------------------------------------------
// pon_onu_grant_queue_unit
// Upstream frame queue of an optical network unit with grant-driven release.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): an enqueue beat offers a
// frame length and tag and returns one status beat (admitted or dropped). A
// grant beat releases head frames in FIFO order while they fit into the
// grant, one release beat each, then closes with a burst report beat that
// carries the queued bits left, overhead plus released bits, and the channel.
// Output channel (out_valid / out_stall / out_data): a single output
// register; last marks the final beat of an item.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the capacity in bits, index 1 the header overhead; cfg_ready is always high.
// Timing: an enqueue status appears in the cycle after acceptance; the block
// takes no new item while a grant is in flight or an output beat is held. A
// grant reads the head entry, releases frames while they fit, then reports
// after the queue empties or a frame does not fit. The frame store read port
// sets the loop rate. Reset clears pointers, counts and the output valid flag;
// the frame store is not cleared. While out_stall is high a held output beat
// stays and the block takes no new item.
// ----------------------------------------------------------------------------
module pon_onu_grant_queue_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pogq_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pogq_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pogq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pogq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import pogq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pogq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pogq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/core/pogq_checker.sv =====
// ----------------------------------------------------------------------------
// pogq_checker
// Port-level checks of the grant queue, bound to the top level.
// ----------------------------------------------------------------------------
module pogq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pogq_pkg::out_item_t out_data
);

  import pogq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken while previous item in flight");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind != KIND_RELEASE)))
    else $error("last flag does not match beat kind");

  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_RELEASE) |->
      (out_data.report_bits == '0) && (out_data.burst_bits == '0) &&
      (out_data.out_channel == '0) && !out_data.accepted)
    else $error("release beat carries report fields");

endmodule

bind pon_onu_grant_queue_unit pogq_checker u_pogq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/tb_pon_onu_grant_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pon_onu_grant_queue_unit
// Self-checking bench for the upstream grant queue unit. A tracker class keeps
// its own copy of the queue and the registers and predicts every status,
// release and report beat. Directed beats cover the field extremes, capacity
// and FIFO limits and zero grants. Random beats then follow under several
// register settings, with bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module tb_pon_onu_grant_queue_unit;
  import pogq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [23:0] GRANT_MAX = 24'hFFFFFF;
  localparam logic [13:0] FRAME_MAX = 14'h3FFF;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HEAVY} stall_mode_t;

  class frame_queue_tracker;
    logic [23:0] capacity;
    logic [11:0] overhead;
    logic [23:0] queued_bits;
    logic [13:0] len_store[QUEUE_DEPTH];
    logic [15:0] tag_store[QUEUE_DEPTH];
    int          head;
    int          tail;
    int          count;
    out_item_t   pending_beats[$];
    int          errors;
    int          items_seen;
    int          beats_seen;
    int          admitted;
    int          dropped;
    int          released;

    function new();
      capacity    = CAPACITY_RESET;
      overhead    = OVERHEAD_RESET;
      queued_bits = '0;
      head        = 0;
      tail        = 0;
      count       = 0;
      errors      = 0;
      items_seen  = 0;
      beats_seen  = 0;
      admitted    = 0;
      dropped     = 0;
      released    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CAPACITY) capacity = data;
      else if (idx == REG_OVERHEAD) overhead = data[11:0];
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function void log_item(in_item_t it);
      out_item_t r;
      int        used;
      bit        ok;
      items_seen++;
      if (it.op == OP_ENQ) begin
        ok = (int'(queued_bits) + int'(it.frame_bits) <= int'(capacity)) &&
             (count < QUEUE_DEPTH);
        r = '0;
        r.kind     = KIND_STATUS;
        r.accepted = ok;
        r.out_tag  = it.frame_tag;
        r.out_bits = it.frame_bits;
        r.last     = 1'b1;
        pending_beats.push_back(r);
        if (ok) begin
          len_store[tail] = it.frame_bits;
          tag_store[tail] = it.frame_tag;
          tail = (tail + 1) % QUEUE_DEPTH;
          count++;
          queued_bits = queued_bits + it.frame_bits;
          admitted++;
        end else begin
          dropped++;
        end
      end else begin
        used = 0;
        if (it.grant_bits != '0) begin
          while (count > 0 && used + int'(len_store[head]) <= int'(it.grant_bits)) begin
            used = used + len_store[head];
            queued_bits = queued_bits - len_store[head];
            r = '0;
            r.kind     = KIND_RELEASE;
            r.out_tag  = tag_store[head];
            r.out_bits = len_store[head];
            pending_beats.push_back(r);
            head = (head + 1) % QUEUE_DEPTH;
            count--;
            released++;
          end
        end
        r = '0;
        r.kind        = KIND_REPORT;
        r.report_bits = queued_bits;
        r.burst_bits  = 25'(overhead) + 25'(used);
        r.out_channel = it.channel_id;
        r.last        = 1'b1;
        pending_beats.push_back(r);
      end
    endfunction

    function void match_field(string name, logic [24:0] want, logic [24:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected, kind %0d", got.kind);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      match_field("kind", 25'(want.kind), 25'(got.kind));
      match_field("accepted", 25'(want.accepted), 25'(got.accepted));
      match_field("out_tag", 25'(want.out_tag), 25'(got.out_tag));
      match_field("out_bits", 25'(want.out_bits), 25'(got.out_bits));
      match_field("report_bits", 25'(want.report_bits), 25'(got.report_bits));
      match_field("burst_bits", want.burst_bits, got.burst_bits);
      match_field("out_channel", 25'(want.out_channel), 25'(got.out_channel));
      match_field("last", 25'(want.last), 25'(got.last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_queue_tracker tracker = new();
  in_item_t           stim_q[$];
  int                 cycle_count = 0;
  stall_mode_t        stall_mode = STALL_NONE;
  int                 stall_left = 0;

  pon_onu_grant_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(5, 40);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default:      out_stall <= (stall_left % 8) > 2;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_beat(out_data);
  end

  function automatic in_item_t make_enq(logic [13:0] bits, logic [15:0] tag);
    in_item_t it;
    it = '0;
    it.op         = OP_ENQ;
    it.frame_bits = bits;
    it.frame_tag  = tag;
    it.grant_bits = 24'($urandom());
    it.channel_id = 8'($urandom());
    return it;
  endfunction

  function automatic in_item_t make_grant(logic [23:0] grant, logic [7:0] chan);
    in_item_t it;
    it = '0;
    it.op         = OP_GRANT;
    it.frame_bits = 14'($urandom());
    it.frame_tag  = 16'($urandom());
    it.grant_bits = grant;
    it.channel_id = chan;
    return it;
  endfunction

  function automatic in_item_t random_item();
    logic [13:0] bits;
    logic [23:0] grant;
    int          pick;
    if ($urandom_range(0, 9) < 8) begin
      pick = $urandom_range(0, 9);
      bits = (pick == 0) ? '0 : (pick == 1) ? FRAME_MAX : 14'($urandom_range(0, 16383));
      return make_enq(bits, 16'($urandom()));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) grant = '0;
    else if (pick == 1) grant = GRANT_MAX;
    else if (pick < 6) grant = 24'($urandom_range(0, 40000));
    else grant = 24'($urandom());
    return make_grant(grant, 8'($urandom()));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.log_item(it);
  endtask

  task automatic drive_items();
    int burst_left;
    int gap;
    burst_left = 0;
    while (stim_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      send_item(stim_q.pop_front());
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(input logic [23:0] cap, input logic [11:0] ovh, input int n);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_OVERHEAD, 24'(ovh));
    repeat (n) stim_q.push_back(random_item());
    drive_items();
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty queue, zero and full grants, zero-length and maximum frames
    stim_q.push_back(make_grant('0, 8'hFF));
    stim_q.push_back(make_grant(GRANT_MAX, 8'h00));
    stim_q.push_back(make_enq('0, 16'h0000));
    stim_q.push_back(make_enq(FRAME_MAX, 16'hFFFF));
    stim_q.push_back(make_enq(14'd100, 16'($urandom())));
    stim_q.push_back(make_grant('0, 8'($urandom())));
    stim_q.push_back(make_grant(24'd1, 8'($urandom())));
    stim_q.push_back(make_grant(24'(FRAME_MAX), 8'($urandom())));
    stim_q.push_back(make_grant(GRANT_MAX, 8'($urandom())));
    drive_items();
    wait_drained();

    // admission right at the capacity bound
    write_reg(REG_CAPACITY, 24'd20000);
    write_reg(REG_OVERHEAD, 24'd4095);
    stim_q.push_back(make_enq(FRAME_MAX, 16'($urandom())));
    stim_q.push_back(make_enq(FRAME_MAX, 16'($urandom())));
    stim_q.push_back(make_enq(14'd3617, 16'($urandom())));
    stim_q.push_back(make_enq(14'd1, 16'($urandom())));
    stim_q.push_back(make_enq('0, 16'($urandom())));
    stim_q.push_back(make_grant(GRANT_MAX, 8'($urandom())));
    stim_q.push_back(make_enq(14'd5000, 16'($urandom())));
    stim_q.push_back(make_enq(14'd7000, 16'($urandom())));
    drive_items();
    wait_drained();

    // capacity dropped below the queued bits
    write_reg(REG_CAPACITY, 24'd0);
    stim_q.push_back(make_enq('0, 16'($urandom())));
    stim_q.push_back(make_enq(14'd1, 16'($urandom())));
    stim_q.push_back(make_grant(24'd5000, 8'($urandom())));
    stim_q.push_back(make_grant(GRANT_MAX, 8'($urandom())));
    stim_q.push_back(make_enq('0, 16'($urandom())));
    stim_q.push_back(make_enq(14'd1, 16'($urandom())));
    stim_q.push_back(make_grant('0, 8'($urandom())));
    stim_q.push_back(make_grant(24'd1, 8'($urandom())));
    drive_items();
    wait_drained();

    // overfill the FIFO, then drain it with one grant
    write_reg(REG_CAPACITY, GRANT_MAX);
    write_reg(REG_OVERHEAD, 24'd0);
    repeat (36) stim_q.push_back(make_enq(14'($urandom_range(0, 16383)), 16'($urandom())));
    stim_q.push_back(make_grant(GRANT_MAX, 8'($urandom())));
    drive_items();
    wait_drained();

    random_phase(24'($urandom()), 12'($urandom()), 15);
    random_phase(24'($urandom_range(50000, 200000)), 12'd4095, 15);
    random_phase(GRANT_MAX, 12'($urandom()), 15);

    $display("Ran %0d items over several capacity/overhead settings, %0d result beats",
             tracker.items_seen, tracker.beats_seen);
    $display("Frames admitted %0d, dropped %0d, released by grants %0d",
             tracker.admitted, tracker.dropped, tracker.released);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pogq_pkg.sv
rtl/core/pogq_ram.sv
rtl/core/pogq_ctrl.sv
rtl/core/pogq_dp.sv
rtl/core/pon_onu_grant_queue_unit.sv
rtl/core/pogq_checker.sv
sim/tb_pon_onu_grant_queue_unit.sv
